>>> rtl/core/rem_pkg.sv
// Shared types and constants for the regulation error monitor.
// Sample, error and filter widths, the fixed-point filter coefficients and the
// register index codes. No dependencies.
package rem_pkg;

	localparam int SAMPLE_W = 24;
	localparam int FILT_W   = 16;
	localparam int COUNT_W  = 16;
	localparam int ERR_W    = SAMPLE_W + 1;
	localparam int ABS_W    = SAMPLE_W + 1;

	// Filter coefficients in unsigned Q0.FILT_W, truncated
	localparam longint unsigned FILT_ONE = 64'd1 << FILT_W;
	localparam logic [FILT_W-1:0] K09   = FILT_W'((FILT_ONE * 9) / 10);
	localparam logic [FILT_W-1:0] INC01 = FILT_W'(FILT_ONE / 10);
	localparam logic [FILT_W-1:0] LVL03 = FILT_W'((FILT_ONE * 3) / 10);

	typedef logic [SAMPLE_W-1:0]        sample_t;
	typedef logic signed [SAMPLE_W-1:0] ssample_t;
	typedef logic signed [ERR_W-1:0]    err_t;
	typedef logic [ABS_W-1:0]           abs_t;
	typedef logic [COUNT_W-1:0]         count_t;
	typedef logic [FILT_W-1:0]          filt_t;

	typedef enum logic [0:0] {
		REG_WARN_THR  = 1'b0,
		REG_FAULT_THR = 1'b1
	} cfg_reg_t;

	// Per-request state update strobes
	typedef struct packed {
		logic sample;
		logic clear;
	} step_t;

endpackage

>>> rtl/core/rem_limit.sv
// One supervision limit: threshold register, exceedance filter and flag.
// Depends on rem_pkg.
module rem_limit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             thr_we,
	input  rem_pkg::sample_t thr_data,
	input  rem_pkg::step_t   step,
	input  rem_pkg::abs_t    abs_err,
	output logic             flag_next
);
	import rem_pkg::*;

	sample_t                thr_q;
	filt_t                  filt_q;
	logic                   state_q;
	logic                   enabled;
	logic                   exceeded;
	logic [2*FILT_W-1:0]    prod;
	filt_t                  filt_upd;
	filt_t                  filt_d;
	logic                   state_d;

	assign enabled = (thr_q != '0);

	// Halve the threshold while the flag is set: compare twice the error instead
	always_comb begin
		if (state_q) begin
			exceeded = {abs_err, 1'b0} > (ABS_W + 1)'(thr_q);
		end else begin
			exceeded = abs_err > ABS_W'(thr_q);
		end
	end

	assign prod     = (2*FILT_W)'(filt_q) * (2*FILT_W)'(K09);
	assign filt_upd = prod[2*FILT_W-1:FILT_W] + (exceeded ? INC01 : '0);

	always_comb begin
		filt_d  = filt_q;
		state_d = state_q;
		if (step.clear) begin
			filt_d  = '0;
			state_d = 1'b0;
		end else if (step.sample && enabled) begin
			filt_d  = filt_upd;
			state_d = (filt_upd > LVL03);
		end
	end

	assign flag_next = state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			filt_q  <= '0;
			state_q <= 1'b0;
		end else if (thr_we) begin
			thr_q <= thr_data;
			if (thr_data == '0) begin
				filt_q  <= '0;
				state_q <= 1'b0;
			end
		end else begin
			filt_q  <= filt_d;
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/rem_max.sv
// Running maximum of the absolute error with the inhibit down-counter.
// Depends on rem_pkg.
module rem_max (
	input  logic             clk,
	input  logic             arst_n,
	input  rem_pkg::step_t   step,
	input  rem_pkg::abs_t    abs_err,
	input  rem_pkg::count_t  load_count,
	output rem_pkg::sample_t max_next
);
	import rem_pkg::*;

	sample_t max_q;
	count_t  cnt_q;
	sample_t abs_sat;
	sample_t max_d;
	count_t  cnt_d;

	// Saturate full-scale error to the top of the sample range
	assign abs_sat = abs_err[ABS_W-1] ? '1 : abs_err[SAMPLE_W-1:0];

	always_comb begin
		max_d = max_q;
		cnt_d = cnt_q;
		if (step.clear) begin
			max_d = '0;
			cnt_d = load_count;
		end else if (step.sample) begin
			if (cnt_q != '0) begin
				cnt_d = cnt_q - COUNT_W'(1);
				// restart tracking when the inhibit window closes
				if (cnt_q == COUNT_W'(1)) begin
					max_d = abs_sat;
				end
			end else if (abs_sat > max_q) begin
				max_d = abs_sat;
			end
		end
	end

	assign max_next = max_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			cnt_q <= '0;
		end else begin
			max_q <= max_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

>>> rtl/core/regulation_error_monitor_core.sv
// Top level of the regulation error monitor: input register, error datapath,
// result register. Depends on rem_pkg, rem_max and rem_limit.
//
// Takes one request per cycle while the output is not stalled and returns one
// result per request: the request waits in the input register, then the
// error, maximum and both limit filters are updated in a single pass into the
// result register. The longest path is the 16 x 16 filter multiply followed by
// the increment and flag compare. While a finished result waits at a stalled
// output, the input register takes one more request and then stalls the input
// until the result is taken. With the output free, sustained throughput is one
// request per clock. The user must write thresholds through the cfg port only
// while no request is in flight; the block does not enforce this. Writing zero
// to a threshold disables that limit and clears its filter and flag.
module regulation_error_monitor_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  rem_pkg::sample_t   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  rem_pkg::ssample_t  ref_sample,
	input  rem_pkg::ssample_t  measured,
	input  rem_pkg::count_t    inhibit_count,
	output logic               out_valid,
	input  logic               out_stall,
	output rem_pkg::err_t      reg_error,
	output rem_pkg::sample_t   max_abs_error,
	output logic               warning_flag,
	output logic               fault_flag
);
	import rem_pkg::*;

	logic     valid_s1;
	logic     cmd_s1;
	ssample_t ref_s1;
	ssample_t meas_s1;
	count_t   count_s1;

	logic     out_valid_q;
	err_t     err_q;
	sample_t  max_q;
	logic     warn_q;
	logic     fault_q;

	logic     accept;
	logic     advance;
	step_t    step;
	err_t     err;
	abs_t     abs_err;
	sample_t  max_next;
	logic     warn_next;
	logic     fault_next;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign step.sample = advance && !cmd_s1;
	assign step.clear  = advance && cmd_s1;

	assign err     = ERR_W'(ref_s1) - ERR_W'(meas_s1);
	assign abs_err = err[ERR_W-1] ? abs_t'(-err) : abs_t'(err);

	rem_max u_max (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.abs_err    (abs_err),
		.load_count (count_s1),
		.max_next   (max_next)
	);

	rem_limit u_warn (
		.clk       (clk),
		.arst_n    (arst_n),
		.thr_we    (cfg_we && (cfg_index == REG_WARN_THR)),
		.thr_data  (cfg_data),
		.step      (step),
		.abs_err   (abs_err),
		.flag_next (warn_next)
	);

	rem_limit u_fault (
		.clk       (clk),
		.arst_n    (arst_n),
		.thr_we    (cfg_we && (cfg_index == REG_FAULT_THR)),
		.thr_data  (cfg_data),
		.step      (step),
		.abs_err   (abs_err),
		.flag_next (fault_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd;
			ref_s1   <= ref_sample;
			meas_s1  <= measured;
			count_s1 <= inhibit_count;
		end
		if (advance) begin
			err_q   <= cmd_s1 ? '0 : err;
			max_q   <= max_next;
			warn_q  <= warn_next;
			fault_q <= fault_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign reg_error     = err_q;
	assign max_abs_error = max_q;
	assign warning_flag  = warn_q;
	assign fault_flag    = fault_q;

	// A held request must leave the input register when the output is free
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_stall |-> !in_stall)
		else $error("input register blocked while output free");

	// A reset command yields an all-zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 |=> (reg_error == '0) && (max_abs_error == '0)
			&& !warning_flag && !fault_flag)
		else $error("reset command result not cleared");

	// Every request moved out of the input register shows up at the output
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result lost after advance");

endmodule
